### rtl/ebpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eBPF ALU64 package
// Shared codes, command and status types for the execute core.
// ----------------------------------------------------------------------------
package ebpf_pkg;

  localparam logic [2:0] CLASS_ALU64 = 3'd7;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_OR   = 4'd4,
    OP_AND  = 4'd5,
    OP_LSH  = 4'd6,
    OP_RSH  = 4'd7,
    OP_NEG  = 4'd8,
    OP_MOD  = 4'd9,
    OP_XOR  = 4'd10,
    OP_MOV  = 4'd11,
    OP_ARSH = 4'd12,
    OP_R13  = 4'd13,
    OP_R14  = 4'd14,
    OP_R15  = 4'd15
  } op_e;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_CLASS  = 2'd1;
  localparam logic [1:0] ST_OP     = 2'd2;
  localparam logic [1:0] ST_BADREG = 2'd3;

  typedef struct packed {
    logic load;     // capture operands and decode
    logic mul_lo;   // first multiplier step
    logic mul_hi;   // second multiplier step
    logic div_step; // one restoring division step
    logic finish;   // compute and write back
  } cmd_t;

  typedef struct packed {
    logic       is_mul;
    logic       is_div;
    logic       div_last;
  } sts_t;

endpackage

### rtl/ebpf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eBPF datapath
// Register file, operand capture, split multiplier, radix-2 divider, ALU.
// ----------------------------------------------------------------------------
module ebpf_datapath #(
  parameter int NUM_REGS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebpf_pkg::cmd_t      cmd_i,
  output ebpf_pkg::sts_t      sts_o,
  input  logic [2:0]          insn_class_i,
  input  logic [3:0]          func_i,
  input  logic                use_src_reg_i,
  input  logic [3:0]          dst_index_i,
  input  logic [3:0]          src_index_i,
  input  logic signed [31:0]  immediate_i,
  output logic [1:0]          status_o,
  output logic [3:0]          written_index_o,
  output logic signed [63:0]  written_value_o
);

  localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [NUM_REGS-1:0][63:0] rf_q;
  logic [63:0] d_q, s_q, acc_q, rem_q, quo_q;
  logic [3:0]  op_q, dst_q;
  logic [1:0]  st_q;
  logic [5:0]  cnt_q;
  logic [1:0]  status_q;
  logic [3:0]  widx_q;
  logic [63:0] wval_q;

  logic        src_used;
  logic [1:0]  st_d;
  logic [63:0] s_sel;

  always_comb begin
    src_used = (func_i != ebpf_pkg::OP_NEG) && use_src_reg_i;
    if (insn_class_i != ebpf_pkg::CLASS_ALU64) begin
      st_d = ebpf_pkg::ST_CLASS;
    end else if (func_i > ebpf_pkg::OP_ARSH) begin
      st_d = ebpf_pkg::ST_OP;
    end else if ({28'd0, dst_index_i} >= NUM_REGS ||
                 (src_used && {28'd0, src_index_i} >= NUM_REGS)) begin
      st_d = ebpf_pkg::ST_BADREG;
    end else begin
      st_d = ebpf_pkg::ST_DONE;
    end
    s_sel = src_used ? rf_q[src_index_i[IW-1:0]] : {{32{immediate_i[31]}}, immediate_i};
  end

  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_q, quo_q[63]};
    rem_sub = rem_sh - {1'b0, s_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q   <= rf_q[dst_index_i[IW-1:0]];
      s_q   <= s_sel;
      op_q  <= func_i;
      dst_q <= dst_index_i;
      st_q  <= st_d;
      quo_q <= rf_q[dst_index_i[IW-1:0]];
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.mul_lo) begin
      acc_q <= d_q[31:0] * s_q[31:0];
    end
    if (cmd_i.mul_hi) begin
      acc_q <= acc_q + {(d_q[63:32] * s_q[31:0]) + (d_q[31:0] * s_q[63:32]), 32'd0};
    end
    if (cmd_i.div_step) begin
      if (!rem_sub[64]) begin
        rem_q <= rem_sub[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
      cnt_q <= cnt_q + 6'd1;
    end
  end

  logic [63:0] res;
  always_comb begin
    res = d_q;
    case (ebpf_pkg::op_e'(op_q))
      ebpf_pkg::OP_ADD:  res = d_q + s_q;
      ebpf_pkg::OP_SUB:  res = d_q - s_q;
      ebpf_pkg::OP_MUL:  res = acc_q;
      ebpf_pkg::OP_DIV:  res = (s_q == '0) ? '0 : quo_q;
      ebpf_pkg::OP_OR:   res = d_q | s_q;
      ebpf_pkg::OP_AND:  res = d_q & s_q;
      ebpf_pkg::OP_LSH:  res = d_q << s_q[5:0];
      ebpf_pkg::OP_RSH:  res = d_q >> s_q[5:0];
      ebpf_pkg::OP_NEG:  res = 64'd0 - d_q;
      ebpf_pkg::OP_MOD:  res = (s_q == '0) ? d_q : rem_q;
      ebpf_pkg::OP_XOR:  res = d_q ^ s_q;
      ebpf_pkg::OP_MOV:  res = s_q;
      ebpf_pkg::OP_ARSH: res = 64'($signed(d_q) >>> s_q[5:0]);
      default:           res = d_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= '0;
    end else if (cmd_i.finish && st_q == ebpf_pkg::ST_DONE) begin
      rf_q[dst_q[IW-1:0]] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= st_q;
      widx_q   <= dst_q;
      wval_q   <= (st_q == ebpf_pkg::ST_DONE) ? res : '0;
    end
  end

  assign sts_o.is_mul   = (st_d == ebpf_pkg::ST_DONE) && (func_i == ebpf_pkg::OP_MUL);
  assign sts_o.is_div   = (st_d == ebpf_pkg::ST_DONE) &&
                          (func_i == ebpf_pkg::OP_DIV || func_i == ebpf_pkg::OP_MOD);
  assign sts_o.div_last = (cnt_q == 6'd63);

  assign status_o        = status_q;
  assign written_index_o = widx_q;
  assign written_value_o = wval_q;

endmodule

### rtl/ebpf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eBPF controller
// Sequences load, multiply, divide, write-back and result handshake.
// ----------------------------------------------------------------------------
module ebpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ebpf_pkg::sts_t sts_i,
  output ebpf_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_comb begin
    in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
    accept      = in_valid_i && in_ready_o;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = sts_i.is_mul ? S_MUL1 : (sts_i.is_div ? S_DIV : S_FIN);
        end
      end
      S_MUL1: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_FIN;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/ebpf_alu64_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eBPF ALU64 execute core
// Runs one decoded ALU64 instruction against an internal register file.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Simple ops and all error cases go from
// acceptance straight to write-back; mul first runs two 32-bit partial product
// steps; div and mod first run the one-bit-per-cycle restoring divider.
// The next transaction is taken once the previous result has been delivered.
// The register file resets to zero.
module ebpf_alu64_execute_core #(
  parameter int NUM_REGS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         insn_class_i,
  input  logic [3:0]         func_i,
  input  logic               use_src_reg_i,
  input  logic [3:0]         dst_index_i,
  input  logic [3:0]         src_index_i,
  input  logic signed [31:0] immediate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [3:0]         written_index_o,
  output logic signed [63:0] written_value_o
);

  ebpf_pkg::cmd_t cmd;
  ebpf_pkg::sts_t sts;

  ebpf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ebpf_datapath #(.NUM_REGS(NUM_REGS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .insn_class_i, .func_i, .use_src_reg_i, .dst_index_i, .src_index_i,
    .immediate_i, .status_o, .written_index_o, .written_value_o
  );

endmodule

### rtl/ebpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eBPF port checker
// Port-level properties of the execute core, bound to the top level.
// ----------------------------------------------------------------------------
module ebpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] written_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(written_value_o))
    else $error("result dropped while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o && !in_ready_o)
    else $error("no work cycle after acceptance");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ebpf_pkg::ST_DONE |-> written_value_o == 64'd0)
    else $error("error result carries a value");

endmodule

bind ebpf_alu64_execute_core ebpf_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .written_value_o(64'(written_value_o))
);
